>>> src/imusf_pkg.sv
// shared constants, types and helpers for the imu sample filter
package imusf_pkg;

	localparam int EST_FRAC_DEFAULT = 16;
	localparam int VAR_FRAC         = 20;
	localparam int VAR_W            = 24;
	localparam int AXIS_W           = 16;
	localparam int NUM_AXES         = 6;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 24;
	localparam int DIV_STEPS        = VAR_FRAC + 1;
	localparam int MUL_A_W          = 33;
	localparam int MUL_B_W          = 22;
	localparam int PROD_W           = MUL_A_W + MUL_B_W;
	localparam int OP_IDX_W         = 4;

	localparam logic [23:0] VAR_RESET      = 24'd20972;
	localparam logic [23:0] PN_RESET       = 24'd1049;
	localparam logic [23:0] MN_RESET       = 24'd569377;
	localparam logic [16:0] EMA_FACTOR     = 17'd9830;
	localparam logic [16:0] EMA_KEEP       = 17'd55706;

	// multiplier op sequence: two per accel axis, two per gyro axis, one variance
	localparam logic [3:0] OP_GYRO_FIRST = 4'd6;
	localparam logic [3:0] OP_VAR        = 4'd12;

	typedef enum logic [2:0] {
		REG_OFF_AX = 3'd0,
		REG_OFF_AY = 3'd1,
		REG_OFF_AZ = 3'd2,
		REG_OFF_GX = 3'd3,
		REG_OFF_GY = 3'd4,
		REG_OFF_GZ = 3'd5,
		REG_PNOISE = 3'd6,
		REG_MNOISE = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic                accept;
		logic                div_step;
		logic                div_first;
		logic                mul_en;
		logic [OP_IDX_W-1:0] mul_idx;
		logic                finish;
	} imusf_cmd_t;

	typedef struct packed {
		logic out_valid;
	} imusf_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

endpackage

>>> src/imusf_ctrl.sv
// sequencing state machine: divider steps, then the multiplier op sequence
module imusf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                m_tready,
	input  imusf_pkg::imusf_sts_t sts,
	output imusf_pkg::imusf_cmd_t cmd
);
	import imusf_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_MUL, ST_FIN} state_t;

	state_t              state_q;
	logic [4:0]          div_cnt_q;
	logic [OP_IDX_W-1:0] op_cnt_q;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.accept    = (state_q == ST_IDLE) && s_tvalid;
		cmd.div_step  = (state_q == ST_DIV);
		cmd.div_first = (div_cnt_q == '0);
		cmd.mul_en    = (state_q == ST_MUL);
		cmd.mul_idx   = op_cnt_q;
		cmd.finish    = (state_q == ST_FIN) && (!sts.out_valid || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
			op_cnt_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					div_cnt_q <= '0;
					op_cnt_q  <= '0;
					if (s_tvalid) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_cnt_q == 5'(DIV_STEPS - 1)) begin
						state_q <= ST_MUL;
					end else begin
						div_cnt_q <= div_cnt_q + 5'd1;
					end
				end
				ST_MUL: begin
					if (op_cnt_q == OP_VAR) begin
						state_q <= ST_FIN;
					end else begin
						op_cnt_q <= op_cnt_q + 4'd1;
					end
				end
				ST_FIN: begin
					if (!sts.out_valid || m_tready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> src/imusf_datapath.sv
// filter state, config registers, gain divider, shared multiplier and output register
module imusf_datapath #(
	parameter int EST_FRAC = imusf_pkg::EST_FRAC_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  imusf_pkg::imusf_cmd_t                cmd,
	output imusf_pkg::imusf_sts_t                sts,
	input  logic                                 cfg_valid,
	input  logic [imusf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [imusf_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [imusf_pkg::NUM_AXES*16-1:0]    s_tdata,
	input  logic                                 m_tready,
	output logic [imusf_pkg::NUM_AXES*16-1:0]    m_tdata
);
	import imusf_pkg::*;

	localparam int XW = AXIS_W + EST_FRAC;
	localparam int DW = ((XW > 32) ? XW : 32) + 1;

	logic signed [15:0] off_q [NUM_AXES];
	logic [23:0]        pn_q, mn_q, var_q;
	logic signed [31:0] est_q [3];
	logic signed [31:0] avg_q [3];
	logic signed [15:0] d_q   [NUM_AXES];
	logic [24:0]        p_q;
	logic [25:0]        den_q;
	logic [26:0]        rem_q;
	logic [20:0]        quo_q;
	logic [15:0]        res_q [NUM_AXES];
	logic [15:0]        out_q [NUM_AXES];
	logic               out_valid_q;
	logic signed [63:0] acc_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic [OP_IDX_W-1:0]      idx_s1;
	logic                     vld_s1;

	function automatic logic [15:0] out16(input logic signed [31:0] v);
		logic signed [32:0] t;
		t = 33'(v);
		if (v < 0) t = t + 33'((64'd1 << EST_FRAC) - 64'd1);
		t = t >>> EST_FRAC;
		if (t > 33'sd32767) return 16'h7fff;
		else if (t < -33'sd32768) return 16'h8000;
		else return t[15:0];
	endfunction

	// gain divider step
	logic [26:0] r_cmp;
	logic        r_ge;
	logic [20:0] g_w;
	assign r_cmp = cmd.div_first ? {2'b00, p_q} : {rem_q[25:0], 1'b0};
	assign r_ge  = (r_cmp >= {1'b0, den_q});
	assign g_w   = (den_q == '0) ? '0 : quo_q;

	// multiplier operand select
	logic signed [MUL_A_W-1:0] a_op;
	logic signed [MUL_B_W-1:0] b_op;
	logic signed [DW-1:0]      x_ext, diff;
	logic [1:0]                ax, gj;
	logic [OP_IDX_W-1:0]       gk;

	always_comb begin
		a_op  = '0;
		b_op  = '0;
		ax    = cmd.mul_idx[2:1];
		gk    = cmd.mul_idx - OP_GYRO_FIRST;
		gj    = gk[2:1];
		x_ext = '0;
		diff  = '0;
		if (cmd.mul_idx < OP_GYRO_FIRST) begin
			x_ext = DW'(d_q[3'(ax)]) <<< EST_FRAC;
			diff  = x_ext - DW'(est_q[ax]);
			if (cmd.mul_idx[0])
				a_op = MUL_A_W'($signed(diff[DW-1:VAR_FRAC]));
			else
				a_op = $signed({13'd0, diff[VAR_FRAC-1:0]});
			b_op = $signed({1'b0, g_w});
		end else if (cmd.mul_idx < OP_VAR) begin
			if (gk[0]) begin
				a_op = MUL_A_W'(d_q[3'(gj) + 3'd3]);
				b_op = $signed({5'd0, EMA_FACTOR});
			end else begin
				a_op = MUL_A_W'(avg_q[gj]);
				b_op = $signed({5'd0, EMA_KEEP});
			end
		end else begin
			a_op = $signed({8'd0, p_q});
			b_op = $signed(22'((22'd1 << VAR_FRAC) - {1'b0, g_w}));
		end
	end

	// product consumption
	logic [1:0]          uax, ugj;
	logic [OP_IDX_W-1:0] ugk;
	logic signed [63:0]  prod64, kal_sum, gyr_sum;
	logic signed [31:0]  kal_new, gyr_new;
	logic [PROD_W-1:0]   var_full;
	logic [23:0]         var_new;

	always_comb begin
		uax      = idx_s1[2:1];
		ugk      = idx_s1 - OP_GYRO_FIRST;
		ugj      = ugk[2:1];
		prod64   = 64'(prod_s1);
		kal_sum  = 64'(est_q[uax]) + acc_q + prod64;
		kal_new  = sat32(kal_sum);
		gyr_sum  = acc_q + (prod64 <<< EST_FRAC);
		gyr_new  = sat32(gyr_sum >>> 16);
		var_full = prod_s1 >>> VAR_FRAC;
		var_new  = (var_full > PROD_W'(24'hffffff)) ? 24'hffffff : var_full[23:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) off_q[i] <= '0;
			pn_q        <= PN_RESET;
			mn_q        <= MN_RESET;
			var_q       <= VAR_RESET;
			for (int i = 0; i < 3; i++) begin
				est_q[i] <= '0;
				avg_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
			vld_s1      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (reg_idx_t'(cfg_index))
					REG_PNOISE: pn_q <= cfg_data;
					REG_MNOISE: mn_q <= cfg_data;
					default:    off_q[cfg_index] <= cfg_data[15:0];
				endcase
			end
			vld_s1 <= cmd.mul_en;
			if (vld_s1) begin
				if (idx_s1 < OP_GYRO_FIRST) begin
					if (idx_s1[0])
						est_q[uax] <= kal_new;
				end else if (idx_s1 < OP_VAR) begin
					if (ugk[0])
						avg_q[ugj] <= gyr_new;
				end else begin
					var_q <= var_new;
				end
			end
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			for (int i = 0; i < NUM_AXES; i++)
				d_q[i] <= $signed(s_tdata[16*i +: 16]) - off_q[i];
			p_q   <= {1'b0, var_q} + {1'b0, pn_q};
			den_q <= {2'b00, var_q} + {2'b00, pn_q} + {2'b00, mn_q};
		end
		if (cmd.div_step) begin
			rem_q <= r_ge ? (r_cmp - {1'b0, den_q}) : r_cmp;
			quo_q <= cmd.div_first ? {20'd0, r_ge} : {quo_q[19:0], r_ge};
		end
		prod_s1 <= a_op * b_op;
		idx_s1  <= cmd.mul_idx;
		if (vld_s1) begin
			if (idx_s1 < OP_GYRO_FIRST) begin
				if (!idx_s1[0]) acc_q <= prod64 >>> VAR_FRAC;
				else res_q[3'(uax)] <= out16(kal_new);
			end else if (idx_s1 < OP_VAR) begin
				if (!ugk[0]) acc_q <= prod64;
				else res_q[3'(ugj) + 3'd3] <= out16(gyr_new);
			end
		end
		if (cmd.finish)
			for (int i = 0; i < NUM_AXES; i++) out_q[i] <= res_q[i];
	end

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) m_tdata[16*i +: 16] = out_q[i];
	end

	assign sts.out_valid = out_valid_q;

endmodule

>>> src/imu_sample_filter_core.sv
// top level of the imu sample filter: kalman on accel axes, exponential average on gyro
//
//  channel   signals                               word
//  s_axis    s_tvalid s_tready s_tdata[95:0]       one raw six-axis sample
//  m_axis    m_tvalid m_tready m_tdata[95:0]       one filtered six-axis sample
//  cfg       cfg_valid cfg_ready cfg_index cfg_data  register write
//
// an item runs through these states, accept to next accept: accept, 21 steps of the
// restoring gain divider, 13 ops through the shared 33x22 multiplier, finish
// the result word is loaded into the output register at finish; one item in flight
// the finished word sits in an output register, so the next sample is taken
// while it waits; finish stalls only if the previous word is still not taken
// reset clears estimates, averages and variance to their start values
module imu_sample_filter_core #(
	parameter int ESTIMATE_FRAC_BITS = imusf_pkg::EST_FRAC_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// acc_x_raw, acc_y_raw, acc_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
	input  logic [imusf_pkg::NUM_AXES*16-1:0]   s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// acc_x_out, acc_y_out, acc_z_out, gyro_x_out, gyro_y_out, gyro_z_out
	output logic [imusf_pkg::NUM_AXES*16-1:0]   m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [imusf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [imusf_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import imusf_pkg::*;

	imusf_cmd_t cmd;
	imusf_sts_t sts;

	// config writes are always taken
	assign cfg_ready = 1'b1;
	assign m_tvalid  = sts.out_valid;

	imusf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	imusf_datapath #(
		.EST_FRAC (ESTIMATE_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
